// File: sv/bri_pkg.sv
// Shared types, widths and register indexes for the box region-of-interest filter.
// Used by every module of the block; depends on nothing.
package bri_pkg;

  // fixed-point formats
  localparam int unsigned CoordW    = 20;
  localparam int unsigned CoefW     = 14;
  localparam int unsigned FracShift = 12;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned RowW      = 62;
  localparam int unsigned OffLsb    = 42;
  localparam int unsigned SizeW     = 20;
  // one extra bit: most negative coef times most negative coordinate is +2^32
  localparam int unsigned ProdW     = CoordW + CoefW + 1;
  localparam int unsigned SumW      = ProdW + 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RowW;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegXformEn = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRowX    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRowY    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRowZ    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSizeX   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSizeY   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSizeZ   = 3'd6;

  // reset values: identity rotation, zero offset, unit box
  localparam logic [RowW-1:0]  RowXRst = 62'd4096;
  localparam logic [RowW-1:0]  RowYRst = 62'd67108864;
  localparam logic [RowW-1:0]  RowZRst = 62'd1099511627776;
  localparam logic [SizeW-1:0] SizeRst = 20'd1024;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [RowW-1:0]          row_t;
  typedef logic [SizeW-1:0]         size_t;

  typedef struct packed {
    logic                      xform_en;
    row_t  [NumAxes-1:0]       rows;
    size_t [NumAxes-1:0]       sizes;
  } cfg_t;

endpackage

// File: sv/bri_cfg_regs.sv
// Configuration register file of the box region-of-interest filter.
// Depends on bri_pkg for register indexes, reset values and the cfg_t bundle.
module bri_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [bri_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [bri_pkg::CfgDataW-1:0]  wr_data_i,
  output bri_pkg::cfg_t                 cfg_o
);

  bri_pkg::cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xform_en <= 1'b0;
      cfg_q.rows[0]  <= bri_pkg::RowXRst;
      cfg_q.rows[1]  <= bri_pkg::RowYRst;
      cfg_q.rows[2]  <= bri_pkg::RowZRst;
      cfg_q.sizes[0] <= bri_pkg::SizeRst;
      cfg_q.sizes[1] <= bri_pkg::SizeRst;
      cfg_q.sizes[2] <= bri_pkg::SizeRst;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        bri_pkg::RegXformEn: cfg_q.xform_en <= wr_data_i[0];
        bri_pkg::RegRowX:    cfg_q.rows[0]  <= wr_data_i;
        bri_pkg::RegRowY:    cfg_q.rows[1]  <= wr_data_i;
        bri_pkg::RegRowZ:    cfg_q.rows[2]  <= wr_data_i;
        bri_pkg::RegSizeX:   cfg_q.sizes[0] <= wr_data_i[bri_pkg::SizeW-1:0];
        bri_pkg::RegSizeY:   cfg_q.sizes[1] <= wr_data_i[bri_pkg::SizeW-1:0];
        bri_pkg::RegSizeZ:   cfg_q.sizes[2] <= wr_data_i[bri_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/bri_map_mul.sv
// First pipeline stage: the nine coefficient-by-coordinate products of the pose matrix.
// Depends on bri_pkg for coordinate, product and row types.
module bri_map_mul (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  bri_pkg::coord_t                         pt_i   [bri_pkg::NumAxes],
  input  bri_pkg::row_t [bri_pkg::NumAxes-1:0]    rows_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output bri_pkg::prod_t                          prod_o [bri_pkg::NumAxes][bri_pkg::NumAxes],
  output bri_pkg::coord_t                         pt_o   [bri_pkg::NumAxes]
);

  logic            valid_q;
  bri_pkg::prod_t  prod_d [bri_pkg::NumAxes][bri_pkg::NumAxes];
  bri_pkg::prod_t  prod_q [bri_pkg::NumAxes][bri_pkg::NumAxes];
  bri_pkg::coord_t pt_q   [bri_pkg::NumAxes];

  assign ready_o = !valid_q || ready_i;

  // row r, column c: Q2.12 coefficient times Q10.10 coordinate
  always_comb begin
    for (int r = 0; r < bri_pkg::NumAxes; r++) begin
      for (int c = 0; c < bri_pkg::NumAxes; c++) begin
        prod_d[r][c] = $signed(rows_i[r][c*bri_pkg::CoefW +: bri_pkg::CoefW])
                     * $signed(pt_i[c]);
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
      pt_q   <= pt_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign pt_o    = pt_q;

endmodule

// File: sv/bri_map_sum.sv
// Second pipeline stage: per-row sum of products, scaled offset and rounding half.
// Depends on bri_pkg for product, sum and row types.
module bri_map_sum (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  bri_pkg::prod_t                          prod_i [bri_pkg::NumAxes][bri_pkg::NumAxes],
  input  bri_pkg::coord_t                         pt_i   [bri_pkg::NumAxes],
  input  bri_pkg::row_t [bri_pkg::NumAxes-1:0]    rows_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output bri_pkg::sum_t                           sum_o  [bri_pkg::NumAxes],
  output bri_pkg::coord_t                         pt_o   [bri_pkg::NumAxes]
);

  localparam bri_pkg::sum_t RoundHalf = bri_pkg::sum_t'(1) << (bri_pkg::FracShift - 1);

  logic            valid_q;
  bri_pkg::sum_t   sum_d [bri_pkg::NumAxes];
  bri_pkg::sum_t   sum_q [bri_pkg::NumAxes];
  bri_pkg::coord_t pt_q  [bri_pkg::NumAxes];

  assign ready_o = !valid_q || ready_i;

  // exact Q15.22 row sum plus half an output lsb
  always_comb begin
    for (int r = 0; r < bri_pkg::NumAxes; r++) begin
      sum_d[r] = $signed(prod_i[r][0]) + $signed(prod_i[r][1]) + $signed(prod_i[r][2])
               + ($signed(rows_i[r][bri_pkg::OffLsb +: bri_pkg::CoordW])
                  <<< bri_pkg::FracShift)
               + RoundHalf;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q <= sum_d;
      pt_q  <= pt_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign pt_o    = pt_q;

endmodule

// File: sv/bri_clip_test.sv
// Last pipeline stage: round and saturate to Q10.10, box bound test, output register.
// Depends on bri_pkg for sum, coordinate and size types.
module bri_clip_test (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  bri_pkg::sum_t                           sum_i  [bri_pkg::NumAxes],
  input  bri_pkg::coord_t                         pt_i   [bri_pkg::NumAxes],
  input  logic                                    xform_en_i,
  input  bri_pkg::size_t [bri_pkg::NumAxes-1:0]   sizes_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output bri_pkg::coord_t                         pt_o   [bri_pkg::NumAxes]
);

  localparam int unsigned ChkW = bri_pkg::CoordW + 2;
  localparam bri_pkg::sum_t SatHi = bri_pkg::sum_t'((1 << (bri_pkg::CoordW - 1)) - 1);
  localparam bri_pkg::sum_t SatLo = bri_pkg::sum_t'(-(1 << (bri_pkg::CoordW - 1)));

  logic                   valid_q;
  logic                   pass;
  bri_pkg::sum_t          shifted [bri_pkg::NumAxes];
  bri_pkg::coord_t        mapped  [bri_pkg::NumAxes];
  bri_pkg::coord_t        box_pt  [bri_pkg::NumAxes];
  logic signed [ChkW-1:0] twice   [bri_pkg::NumAxes];
  logic signed [ChkW-1:0] lim     [bri_pkg::NumAxes];
  bri_pkg::coord_t        pt_q    [bri_pkg::NumAxes];

  assign ready_o = !valid_q || ready_i;

  // floor to Q10.10, clamp, pick box-frame or raw point, then -size <= 2c <= size
  always_comb begin
    pass = 1'b1;
    for (int a = 0; a < bri_pkg::NumAxes; a++) begin
      shifted[a] = sum_i[a] >>> bri_pkg::FracShift;
      if (shifted[a] > SatHi) begin
        mapped[a] = SatHi[bri_pkg::CoordW-1:0];
      end else if (shifted[a] < SatLo) begin
        mapped[a] = SatLo[bri_pkg::CoordW-1:0];
      end else begin
        mapped[a] = shifted[a][bri_pkg::CoordW-1:0];
      end
      box_pt[a] = xform_en_i ? mapped[a] : pt_i[a];
      twice[a]  = {box_pt[a][bri_pkg::CoordW-1], box_pt[a], 1'b0};
      lim[a]    = $signed({2'b00, sizes_i[a]});
      if ((twice[a] < -lim[a]) || (twice[a] > lim[a])) begin
        pass = 1'b0;
      end
    end
  end

  // output valid, dropped points never set it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && pass;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o && pass) begin
      pt_q <= box_pt;
    end
  end

  assign valid_o = valid_q;
  assign pt_o    = pt_q;

endmodule

// File: sv/box_region_of_interest_filter.sv
// Top level of the box region-of-interest point filter.
// Depends on bri_pkg, bri_cfg_regs, bri_map_mul, bri_map_sum and bri_clip_test.
//
// Usage:
//   point channel (point_valid_i/point_ready_o) takes one Q10.10 point per beat.
//   kept channel (kept_valid_o/kept_ready_i) gives the point (box frame if the
//   transform is on) when inside the box on all three axes; else no beat at all.
//   cfg channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i with
//   cfg_data_i; it is always ready and is meant to be used while no point is
//   in flight. Indexes past the last register are ignored.
// Timing:
//   three register stages (products, row sums, round/clip/test with the output
//   register); a kept point passes through all three before it shows on the
//   output. One point per cycle is taken when the output is not stalled.
// Reset:
//   all stages empty, transform off, identity matrix, unit box on every axis.
// Stall:
//   a low kept_ready_i holds the output register; the stages behind it keep
//   filling, and point_ready_o drops once all three hold a point.
module box_region_of_interest_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bri_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bri_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           point_valid_i,
  output logic                           point_ready_o,
  input  logic signed [bri_pkg::CoordW-1:0] point_x_i,
  input  logic signed [bri_pkg::CoordW-1:0] point_y_i,
  input  logic signed [bri_pkg::CoordW-1:0] point_z_i,
  output logic                           kept_valid_o,
  input  logic                           kept_ready_i,
  output logic signed [bri_pkg::CoordW-1:0] kept_x_o,
  output logic signed [bri_pkg::CoordW-1:0] kept_y_o,
  output logic signed [bri_pkg::CoordW-1:0] kept_z_o
);

  bri_pkg::cfg_t   cfg;
  bri_pkg::coord_t in_pt  [bri_pkg::NumAxes];
  bri_pkg::coord_t s1_pt  [bri_pkg::NumAxes];
  bri_pkg::coord_t s2_pt  [bri_pkg::NumAxes];
  bri_pkg::coord_t out_pt [bri_pkg::NumAxes];
  bri_pkg::prod_t  s1_prod [bri_pkg::NumAxes][bri_pkg::NumAxes];
  bri_pkg::sum_t   s2_sum  [bri_pkg::NumAxes];
  logic            s1_valid, s1_ready;
  logic            s2_valid, s2_ready;

  // configuration
  assign cfg_ready_o = 1'b1;

  bri_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // input point
  assign in_pt[0] = point_x_i;
  assign in_pt[1] = point_y_i;
  assign in_pt[2] = point_z_i;

  // stage 1: products
  bri_map_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (point_valid_i),
    .ready_o (point_ready_o),
    .pt_i    (in_pt),
    .rows_i  (cfg.rows),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .prod_o  (s1_prod),
    .pt_o    (s1_pt)
  );

  // stage 2: row sums
  bri_map_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .prod_i  (s1_prod),
    .pt_i    (s1_pt),
    .rows_i  (cfg.rows),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .sum_o   (s2_sum),
    .pt_o    (s2_pt)
  );

  // stage 3: clamp, bound test, output register
  bri_clip_test u_clip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_valid),
    .ready_o    (s2_ready),
    .sum_i      (s2_sum),
    .pt_i       (s2_pt),
    .xform_en_i (cfg.xform_en),
    .sizes_i    (cfg.sizes),
    .valid_o    (kept_valid_o),
    .ready_i    (kept_ready_i),
    .pt_o       (out_pt)
  );

  assign kept_x_o = out_pt[0];
  assign kept_y_o = out_pt[1];
  assign kept_z_o = out_pt[2];

  // input backpressure only when every stage holds a point and the output stalls
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_ready_o |-> (s1_valid && s2_valid && kept_valid_o && !kept_ready_i))
    else $error("input blocked while the pipeline has room");

  // a new output beat comes only from a point that sat in stage 2
  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(kept_valid_o) |-> $past(s2_valid))
    else $error("output beat with no point in stage 2");

  // a stalled stage-1 point is not lost
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |=> s1_valid)
    else $error("stage 1 point dropped under stall");

  // a write of the transform enable lands
  a_cfg_en_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == bri_pkg::RegXformEn)) |=>
      (cfg.xform_en == $past(cfg_data_i[0])))
    else $error("transform enable write lost");

endmodule
